FILE: rtl/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

   // Mode codes
   localparam logic [2:0] MODE_OFF     = 3'd0;
   localparam logic [2:0] MODE_SET_SEC = 3'd1;
   localparam logic [2:0] MODE_SET_MIN = 3'd2;
   localparam logic [2:0] MODE_PAUSE   = 3'd3;
   localparam logic [2:0] MODE_RUN     = 3'd4;

   // Item kinds
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_BUTTON  = 2'd1;
   localparam logic [1:0] OP_ENCODER = 2'd2;

   // Buttons that matter
   localparam logic [1:0] BUTTON_FWD  = 2'd1;
   localparam logic [1:0] BUTTON_BACK = 2'd2;

   localparam int TIMEOUT_W = 17;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'd60000;

   // Remaining time kept as mixed-radix digits: minutes, seconds, milliseconds
   typedef struct packed {
      logic [6:0] minutes;
      logic [5:0] seconds;
      logic [9:0] millis;
   } time_type;

   localparam time_type TIME_RESET = '{minutes: 7'd0, seconds: 6'd30, millis: 10'd0};

   // Next state and result of one word
   typedef struct packed {
      logic [2:0]           mode;
      time_type             remaining;
      logic [TIMEOUT_W-1:0] elapsed;
      logic                 expired;
   } step_type;

   // (sec + delta) mod 60, sec in 0..59, delta in -128..127
   function automatic logic [5:0] wrap_sec(logic [5:0] sec, logic signed [7:0] delta);
      logic [8:0] sum;
      logic [9:0] r;
      sum = {3'b000, sec} + {delta[7], delta};
      r = {sum[8], sum} + 10'd180;
      if (r >= 10'd240) r = r - 10'd240;
      if (r >= 10'd120) r = r - 10'd120;
      if (r >= 10'd60)  r = r - 10'd60;
      return r[5:0];
   endfunction

   // (min + delta) mod 100, min in 0..99, delta in -128..127
   function automatic logic [6:0] wrap_min(logic [6:0] mins, logic signed [7:0] delta);
      logic [8:0] sum;
      logic [9:0] r;
      sum = {2'b00, mins} + {delta[7], delta};
      r = {sum[8], sum} + 10'd200;
      if (r >= 10'd400) r = r - 10'd400;
      if (r >= 10'd200) r = r - 10'd200;
      if (r >= 10'd100) r = r - 10'd100;
      return r[6:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ctc_step.sv
`default_nettype none

module ctc_step
   import ctc_pkg::*;
(
   input  wire logic [2:0]           mode,
   input  wire time_type             remaining,
   input  wire logic [TIMEOUT_W-1:0] elapsed,
   input  wire logic [TIMEOUT_W-1:0] timeout,
   input  wire logic [1:0]           op,
   input  wire logic [1:0]           button_id,
   input  wire logic signed [7:0]    encoder_delta,
   output step_type                  nxt
);

   logic [TIMEOUT_W-1:0] elapsed_inc;
   time_type             dec_time;
   logic                 rem_zero;
   logic                 dec_zero;

   assign elapsed_inc = (elapsed == {TIMEOUT_W{1'b1}}) ? elapsed : elapsed + 1'b1;
   assign rem_zero    = (remaining == '0);

   // Mixed-radix decrement, held at zero
   always_comb begin
      dec_time = remaining;
      if (!rem_zero) begin
         if (remaining.millis != 10'd0) begin
            dec_time.millis = remaining.millis - 10'd1;
         end else begin
            dec_time.millis = 10'd999;
            if (remaining.seconds != 6'd0) begin
               dec_time.seconds = remaining.seconds - 6'd1;
            end else begin
               dec_time.seconds = 6'd59;
               dec_time.minutes = remaining.minutes - 7'd1;
            end
         end
      end
   end

   assign dec_zero = (dec_time == '0);

   always_comb begin
      nxt.mode      = mode;
      nxt.remaining = remaining;
      nxt.elapsed   = elapsed;
      nxt.expired   = 1'b0;
      case (op)
         OP_TICK: begin
            nxt.elapsed = elapsed_inc;
            case (mode)
               MODE_SET_SEC: begin
                  if (elapsed_inc >= timeout) begin
                     nxt.mode    = MODE_OFF;
                     nxt.elapsed = '0;
                  end
               end
               MODE_SET_MIN: begin
                  if (elapsed_inc >= timeout) begin
                     nxt.mode    = MODE_PAUSE;
                     nxt.elapsed = '0;
                  end
               end
               MODE_RUN: begin
                  nxt.remaining = dec_time;
                  if (dec_zero) begin
                     nxt.mode    = MODE_OFF;
                     nxt.elapsed = '0;
                     nxt.expired = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         OP_BUTTON: begin
            case (mode)
               MODE_OFF: begin
                  if (button_id == BUTTON_FWD) nxt.mode = MODE_SET_SEC;
               end
               MODE_SET_SEC: begin
                  if (button_id == BUTTON_FWD)       nxt.mode = MODE_SET_MIN;
                  else if (button_id == BUTTON_BACK) nxt.mode = MODE_OFF;
               end
               MODE_SET_MIN: begin
                  if (button_id == BUTTON_FWD)       nxt.mode = MODE_PAUSE;
                  else if (button_id == BUTTON_BACK) nxt.mode = MODE_SET_SEC;
               end
               MODE_PAUSE: begin
                  if (button_id == BUTTON_FWD)       nxt.mode = MODE_RUN;
                  else if (button_id == BUTTON_BACK) nxt.mode = MODE_SET_MIN;
               end
               MODE_RUN: begin
                  if (button_id == BUTTON_BACK) nxt.mode = MODE_PAUSE;
               end
               default: ;
            endcase
            if (nxt.mode != mode) nxt.elapsed = '0;
         end
         OP_ENCODER: begin
            if (mode == MODE_SET_SEC) begin
               nxt.remaining.seconds = wrap_sec(remaining.seconds, encoder_delta);
            end else if (mode == MODE_SET_MIN) begin
               nxt.remaining.minutes = wrap_min(remaining.minutes, encoder_delta);
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/countdown_timer_controller.sv
// Countdown timer controller.
// Request channel (req_valid / req_stall) carries one word per event: a
// one-millisecond tick, a button press (buttons 1 and 2 act) or an encoder
// step count. Every accepted word gives exactly one response word on the
// rsp_ channel: minutes, seconds and mode after the event, plus an expired
// flag raised on the tick at which a running countdown reaches zero.
// The response word is registered at the edge that accepts the request.
// Throughput is one word per cycle while no response is stalled, set by
// the single next-state step between the state and response registers.
// When rsp_stall is high the response register holds its word and a new
// request is taken only in a cycle where that word leaves; req_stall is high
// exactly while a held response is stalled.
// csr_wr_en / csr_wr_data write the inactivity timeout in milliseconds; write
// it only while no event is in flight.
// Synchronous reset gives mode off, 00:30 remaining, timeout 60000 ms and an
// empty response register.
`default_nettype none

module countdown_timer_controller
   import ctc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_op,
   input  wire logic [1:0]           req_button_id,
   input  wire logic signed [7:0]    req_encoder_delta,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [6:0]                rsp_minutes,
   output logic [5:0]                rsp_seconds,
   output logic [2:0]                rsp_mode,
   output logic                      rsp_expired,
   input  wire logic                 csr_wr_en,
   input  wire logic [TIMEOUT_W-1:0] csr_wr_data
);

   // Timer state
   logic [2:0]           mode_ff;
   time_type             remaining_ff;
   logic [TIMEOUT_W-1:0] elapsed_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   // Response register
   logic       rsp_valid_ff;
   logic [6:0] rsp_minutes_ff;
   logic [5:0] rsp_seconds_ff;
   logic [2:0] rsp_mode_ff;
   logic       rsp_expired_ff;

   step_type nxt;
   logic     accept;

   ctc_step u_step (
      .mode          (mode_ff),
      .remaining     (remaining_ff),
      .elapsed       (elapsed_ff),
      .timeout       (timeout_ff),
      .op            (req_op),
      .button_id     (req_button_id),
      .encoder_delta (req_encoder_delta),
      .nxt           (nxt)
   );

   // Hold the request side only while a finished word is stuck at the output
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Advance the timer state on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         remaining_ff <= TIME_RESET;
         elapsed_ff   <= '0;
      end else if (accept) begin
         mode_ff      <= nxt.mode;
         remaining_ff <= nxt.remaining;
         elapsed_ff   <= nxt.elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset; load it with the word just taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_minutes_ff <= nxt.remaining.minutes;
         rsp_seconds_ff <= nxt.remaining.seconds;
         rsp_mode_ff    <= nxt.mode;
         rsp_expired_ff <= nxt.expired;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_minutes = rsp_minutes_ff;
   assign rsp_seconds = rsp_seconds_ff;
   assign rsp_mode    = rsp_mode_ff;
   assign rsp_expired = rsp_expired_ff;

endmodule

`default_nettype wire
